// File: sv/assert_macros.svh
// assertion helpers for the scaler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a must hold in every cycle outside reset
`define CHECK_ALWAYS(label, a) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) else $error("check failed");

// antecedent a implies consequent b in the next cycle
`define CHECK_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("check failed");

`endif

// File: sv/irs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler package
// shared constants, register indexes and item types for the image scaler
// ----------------------------------------------------------------------------
package irs_pkg;
  localparam int unsigned DEF_MAX_WIDTH    = 256;
  localparam int unsigned DEF_MAX_HEIGHT   = 256;
  localparam int unsigned DEF_MAX_CHANNELS = 4;

  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_INTERP_MODE = 3'd4;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;
  localparam logic MODE_NEAREST = 1'b0;

  typedef struct packed {
    logic        func;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  channel;
    logic [15:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sample_out;
  } out_item_t;

  // coordinate mapper handshake: start a map, report a finished one
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } map_ctl_t;
endpackage

// File: sv/irs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream interface
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface irs_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/irs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generic ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module irs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/irs_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate mapper
// restoring divider giving floor(num / den), one quotient bit per cycle
// ----------------------------------------------------------------------------
module irs_map
  import irs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [41:0] num,
  input  logic [13:0] den,
  output logic        busy,
  output logic        done,
  output logic [41:0] quo
);
  logic [5:0]  cnt;
  logic [41:0] q;
  logic [14:0] rem;
  logic [13:0] dv;
  logic [15:0] trial;

  assign trial = {rem, q[41]} - {2'b0, dv};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd42;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (!trial[15]) begin
        rem <= trial[14:0];
        q   <= {q[40:0], 1'b1};
      end else begin
        rem <= {rem[13:0], q[41]};
        q   <= {q[40:0], 1'b0};
      end
    end
  end

  `include "assert_macros.svh"
  `CHECK_NEXT(a_done_pulse, done, !done)
  `CHECK_ALWAYS(a_not_both, !(busy && done))
  `CHECK_NEXT(a_start_busy, start, busy)
endmodule

// File: sv/image_resize_nearest_bilinear.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image scaler top level
// planar nearest / bilinear resampler over an on-chip image store
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries items {func, col, row, channel, sample_in}. a load item
//   writes one sample into the image store and gives no result. a compute
//   item gives one sample_out item on out_ch. write the apb registers
//   (source size, destination size, mode) only while the block is idle.
// timing:
//   one item at a time. a load is written at the edge that takes it, so loads
//   can come back to back. a compute item maps x and y on one shared 42-step
//   divider, reads the single-port store once (nearest) or four times
//   (bilinear), each read through S_READ and S_WAIT, and for bilinear blends
//   through S_MULA, S_MULB and S_MULC before S_OUT registers the result.
//   the divider sets the rate.
// reset:
//   rst is synchronous; registers go to 256/256/256/256/bilinear. the store
//   is not cleared: reading a never written sample gives an arbitrary value.
// stall:
//   the result waits in an output register; the next item is taken once
//   the result has been taken.
// ----------------------------------------------------------------------------
module image_resize_nearest_bilinear
  import irs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst,
  irs_stream_if.sink            in_ch,
  irs_stream_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MAPX  = 10'b0000000010,
    S_MAPY  = 10'b0000000100,
    S_POS   = 10'b0000001000,
    S_READ  = 10'b0000010000,
    S_WAIT  = 10'b0000100000,
    S_MULA  = 10'b0001000000,
    S_MULB  = 10'b0010000000,
    S_MULC  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0]  src_width, src_height;
  logic [12:0] dst_width, dst_height;
  logic        interp_mode;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= 9'd256;
      src_height  <= 9'd256;
      dst_width   <= 13'd256;
      dst_height  <= 13'd256;
      interp_mode <= 1'b1;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_SRC_WIDTH:   src_width   <= pwdata[8:0];
        REG_SRC_HEIGHT:  src_height  <= pwdata[8:0];
        REG_DST_WIDTH:   dst_width   <= pwdata[12:0];
        REG_DST_HEIGHT:  dst_height  <= pwdata[12:0];
        REG_INTERP_MODE: interp_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SRC_WIDTH:   prdata = {23'd0, src_width};
      REG_SRC_HEIGHT:  prdata = {23'd0, src_height};
      REG_DST_WIDTH:   prdata = {19'd0, dst_width};
      REG_DST_HEIGHT:  prdata = {19'd0, dst_height};
      REG_INTERP_MODE: prdata = {31'd0, interp_mode};
      default:         prdata = '0;
    endcase
  end

  // saturated sizes
  logic [12:0] sw, sh;
  logic [12:0] dw, dh;
  assign sw = (src_width == 9'd0) ? 13'd1 :
              ({4'd0, src_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, src_width};
  assign sh = (src_height == 9'd0) ? 13'd1 :
              ({4'd0, src_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, src_height};
  assign dw = (dst_width == 13'd0) ? 13'd1 : dst_width;
  assign dh = (dst_height == 13'd0) ? 13'd1 : dst_height;

  // latched item
  in_item_t    it;
  logic        accept;
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign accept = in_ch.valid && in_ch.ready;

  // divider: (2d+1)*s << 16 over 2*D
  logic        mstart, mbusy, mdone;
  logic [41:0] mnum, mquo;
  logic [13:0] mden;
  map_ctl_t    mctl;
  logic [12:0] dsel;
  logic [12:0] ssel;
  logic [25:0] prod;

  assign dsel = (state == S_IDLE) ? {1'b0, in_ch.data.col} : {1'b0, it.row};
  assign ssel = (state == S_IDLE) ? sw : sh;
  assign prod = {dsel[11:0], 1'b1} * ssel;
  assign mnum = {prod, 16'd0};
  assign mden = (state == S_IDLE) ? {dw, 1'b0} : {dh, 1'b0};

  irs_map u_map (
    .clk(clk), .rst(rst), .start(mstart), .num(mnum), .den(mden),
    .busy(mbusy), .done(mdone), .quo(mquo)
  );
  assign mctl = '{start: mstart, busy: mbusy, done: mdone};

  logic        is_compute;
  assign is_compute = accept && in_ch.data.func == FUNC_COMPUTE &&
                      32'(in_ch.data.channel) < MAX_CHANNELS;
  assign mstart = is_compute || (state == S_MAPX && mctl.done);

  // positions saturate at 27 bits: anything larger lies far past the right
  // or bottom edge and clamps there anyway
  logic [26:0] qx, qy;
  // integer part of floor(pos): floor((q-32768)/65536) = (q>>16) - (q[15]==0)
  logic signed [14:0] ix, iy;
  logic [15:0]        fx, fy;
  logic [CW-1:0]      chr;

  // neighbor coordinate clamp
  function automatic logic [12:0] clampc(input logic signed [14:0] v,
                                         input logic [12:0] size);
    if (v < 0) return 13'd0;
    if (v > $signed({2'b0, size}) - 15'sd1) return size - 13'd1;
    return v[12:0];
  endfunction

  logic [1:0]  nidx;
  logic signed [14:0] nx, ny;
  logic [12:0] cx, cy;
  logic [AW-1:0] raddr, waddr, addr;
  logic        we;

  assign nx = ix + ((interp_mode != MODE_NEAREST && nidx[0]) ? 15'sd1 : 15'sd0);
  assign ny = iy + ((interp_mode != MODE_NEAREST && nidx[1]) ? 15'sd1 : 15'sd0);
  assign cx = clampc(nx, sw);
  assign cy = clampc(ny, sh);
  assign raddr = AW'((32'(chr) * MAX_HEIGHT + 32'(cy)) * MAX_WIDTH + 32'(cx));
  assign waddr = AW'((32'(in_ch.data.channel) * MAX_HEIGHT + 32'(in_ch.data.row))
                     * MAX_WIDTH + 32'(in_ch.data.col));
  assign we = accept && in_ch.data.func == FUNC_LOAD &&
              32'(in_ch.data.col) < MAX_WIDTH && 32'(in_ch.data.row) < MAX_HEIGHT &&
              32'(in_ch.data.channel) < MAX_CHANNELS;
  assign addr = (state == S_IDLE) ? waddr : raddr;

  logic [15:0] rdata;
  irs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(in_ch.data.sample_in), .rdata(rdata)
  );

  logic [15:0] v [4];
  logic [32:0] top, bot;
  logic [48:0] p0, p1;
  logic [49:0] tot;
  logic [15:0] res;
  logic        rd_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      nidx         <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      rd_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && in_ch.data.func == FUNC_COMPUTE) begin
            if (is_compute) begin
              state <= S_MAPX;
            end else begin
              out_ch.data.sample_out <= '0;
              out_ch.valid <= 1'b1;
            end
          end
        end
        S_MAPX: if (mctl.done) state <= S_MAPY;
        S_MAPY: if (mctl.done) state <= S_POS;
        S_POS: begin
          nidx  <= '0;
          state <= S_READ;
        end
        S_READ: begin
          rd_pend <= 1'b1;
          state   <= S_WAIT;
        end
        S_WAIT: begin
          if (rd_pend) begin
            v[nidx] <= rdata;
            if (interp_mode == MODE_NEAREST) begin
              out_ch.data.sample_out <= rdata;
              out_ch.valid <= 1'b1;
              state <= S_IDLE;
            end else if (nidx == 2'd3) begin
              state <= S_MULA;
            end else begin
              nidx  <= nidx + 2'd1;
              state <= S_READ;
            end
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_MULC;
        S_MULC: state <= S_OUT;
        S_OUT: begin
          out_ch.data.sample_out <= res;
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // position and blend datapath
  logic [16:0] wx0, wy0;
  assign wx0 = 17'h10000 - {1'b0, fx};
  assign wy0 = 17'h10000 - {1'b0, fy};

  always_ff @(posedge clk) begin
    if (accept) begin
      it <= in_ch.data;
      chr <= CW'(in_ch.data.channel);
    end
    if (state == S_MAPX && mctl.done) qx <= (|mquo[41:27]) ? '1 : mquo[26:0];
    if (state == S_MAPY && mctl.done) qy <= (|mquo[41:27]) ? '1 : mquo[26:0];
    if (state == S_POS) begin
      fx <= qx[15:0] ^ 16'h8000;
      fy <= qy[15:0] ^ 16'h8000;
      if (interp_mode == MODE_NEAREST) begin
        // round half away: pos>=0 so floor((q - 32768 + 32768)/65536)
        // pos<0 only for q<32768, which rounds to zero
        ix <= $signed({4'd0, qx[26:16]});
        iy <= $signed({4'd0, qy[26:16]});
      end else begin
        ix <= $signed({4'd0, qx[26:16]}) - (qx[15] ? 15'sd0 : 15'sd1);
        iy <= $signed({4'd0, qy[26:16]}) - (qy[15] ? 15'sd0 : 15'sd1);
      end
    end
    if (state == S_MULA) begin
      top <= v[0] * wx0 + v[1] * {1'b0, fx};
      bot <= v[2] * wx0 + v[3] * {1'b0, fx};
    end
    if (state == S_MULB) begin
      p0 <= {16'd0, top} * {32'd0, wy0};
      p1 <= {16'd0, bot} * {33'd0, fy};
    end
    if (state == S_MULC) begin
      tot <= {1'b0, p0} + {1'b0, p1} + 50'h0_8000_0000;
    end
  end
  assign res = (tot[49:32] > 18'hFFFF) ? 16'hFFFF : tot[47:32];

  `include "assert_macros.svh"
  `CHECK_ALWAYS(a_busy_not_idle, !(mctl.busy && state == S_IDLE))
  `CHECK_NEXT(a_no_take_while_full, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `CHECK_ALWAYS(a_write_only_idle, !(we && state != S_IDLE))
endmodule

// File: test/image_resize_nearest_bilinear_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler result checker
// follows the register writes and every item, keeps its own image store and
// predicts each resized sample, then compares it with the block's output
// ----------------------------------------------------------------------------
module image_resize_nearest_bilinear_checker
  import irs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  irs_stream_if       in_ch,
  irs_stream_if       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);
  localparam int unsigned STORE_DEPTH = DEF_MAX_CHANNELS * DEF_MAX_HEIGHT * DEF_MAX_WIDTH;

  logic [15:0] image_mirror [0:STORE_DEPTH-1];
  logic [8:0]  cur_src_w, cur_src_h;
  logic [12:0] cur_dst_w, cur_dst_h;
  logic        cur_mode;
  logic [15:0] expected_samples [$];

  assign pending = expected_samples.size();

  // source position in 16.16 fixed point, centre aligned
  function automatic longint map_pos(longint d, longint s, longint dd);
    longint num;
    num = ((2 * d + 1) * s) <<< 16;
    return num / (2 * dd) - 32768;
  endfunction

  function automatic longint clamp_to(longint v, longint size);
    if (v < 0) return 0;
    if (v > size - 1) return size - 1;
    return v;
  endfunction

  function automatic longint pixel_at(longint ch, longint x, longint y, longint sw, longint sh);
    return image_mirror[(ch * DEF_MAX_HEIGHT + clamp_to(y, sh)) * DEF_MAX_WIDTH
                        + clamp_to(x, sw)];
  endfunction

  function automatic longint round_away(longint p);
    if (p >= 0) return (p + 32768) >>> 16;
    return -((-p + 32768) >>> 16);
  endfunction

  function automatic logic [15:0] resample_sample(in_item_t it);
    longint sw, sh, dw, dh, px, py, ix, iy, dx, dy;
    longint v00, v10, v01, v11, top, bot, r;
    sw = (cur_src_w == 0) ? 1 : (cur_src_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_src_w;
    sh = (cur_src_h == 0) ? 1 : (cur_src_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_src_h;
    dw = (cur_dst_w == 0) ? 1 : cur_dst_w;
    dh = (cur_dst_h == 0) ? 1 : cur_dst_h;
    px = map_pos(it.col, sw, dw);
    py = map_pos(it.row, sh, dh);
    if (cur_mode == MODE_NEAREST)
      return 16'(pixel_at(it.channel, round_away(px), round_away(py), sw, sh));
    ix = ((px + 65536) >>> 16) - 1;
    iy = ((py + 65536) >>> 16) - 1;
    dx = px - ix * 65536;
    dy = py - iy * 65536;
    v00 = pixel_at(it.channel, ix, iy, sw, sh);
    v10 = pixel_at(it.channel, ix + 1, iy, sw, sh);
    v01 = pixel_at(it.channel, ix, iy + 1, sw, sh);
    v11 = pixel_at(it.channel, ix + 1, iy + 1, sw, sh);
    top = v00 * (65536 - dx) + v10 * dx;
    bot = v01 * (65536 - dx) + v11 * dx;
    r = (top * (65536 - dy) + bot * dy + (64'sd1 <<< 31)) >>> 32;
    if (r > 65535) r = 65535;
    return 16'(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_src_w <= 9'd256;
      cur_src_h <= 9'd256;
      cur_dst_w <= 13'd256;
      cur_dst_h <= 13'd256;
      cur_mode  <= ~MODE_NEAREST;
      errors    <= 0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SRC_WIDTH:   cur_src_w <= pwdata[8:0];
          REG_SRC_HEIGHT:  cur_src_h <= pwdata[8:0];
          REG_DST_WIDTH:   cur_dst_w <= pwdata[12:0];
          REG_DST_HEIGHT:  cur_dst_h <= pwdata[12:0];
          REG_INTERP_MODE: cur_mode  <= pwdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.func == FUNC_LOAD) begin
          if (in_ch.data.col < DEF_MAX_WIDTH && in_ch.data.row < DEF_MAX_HEIGHT)
            image_mirror[(in_ch.data.channel * DEF_MAX_HEIGHT + in_ch.data.row)
                         * DEF_MAX_WIDTH + in_ch.data.col] = in_ch.data.sample_in;
        end else begin
          expected_samples.push_back(resample_sample(in_ch.data));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h",
                   $time, out_ch.data.sample_out);
          errors <= errors + 1;
        end else begin
          if (out_ch.data.sample_out !== expected_samples[0]) begin
            $display("%0t: sample_out mismatch, expected %h, actual %h",
                     $time, expected_samples[0], out_ch.data.sample_out);
            errors <= errors + 1;
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end
endmodule

// File: test/image_resize_nearest_bilinear_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler testbench
// fills small source images, resizes them under many size and mode settings
// with random gaps on both channels, and lets the checker judge each sample
// ----------------------------------------------------------------------------
module image_resize_nearest_bilinear_tb;
  import irs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 1650;
  localparam int CALM_AFTER     = 1450;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          items_sent;
  int          idle_cycles;
  int          ready_hold;
  bit          calm;
  bit          chan_ready [4];

  irs_stream_if #(.T(in_item_t))  in_ch (clk);
  irs_stream_if #(.T(out_item_t)) out_ch (clk);

  image_resize_nearest_bilinear DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  image_resize_nearest_bilinear_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  // clock, period 10 ns
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: ready drops in random bursts, steady at the end
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ch.ready <= 1'b1;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 12);
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 40);
    end
  end

  // watchdog: cycles in which no item, result or register write moves
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one item on the input channel; valid stays high for a following item
  task automatic send_item(logic func, int col, int row, int ch, int smp);
    in_item_t it;
    int gap;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
    it.func      = func;
    it.col       = 12'(col);
    it.row       = 12'(row);
    it.channel   = 2'(ch);
    it.sample_in = 16'(smp);
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // let all results drain and the last load settle before a register write
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int sw, int sh, int dw, int dh, logic mode);
    wait_idle();
    reg_write(REG_SRC_WIDTH, sw | ($urandom() & 32'hFFFF_FE00));
    reg_write(REG_SRC_HEIGHT, sh | ($urandom() & 32'hFFFF_FE00));
    reg_write(REG_DST_WIDTH, dw | ($urandom() & 32'hFFFF_E000));
    reg_write(REG_DST_HEIGHT, dh | ($urandom() & 32'hFFFF_E000));
    reg_write(REG_INTERP_MODE, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, mode});
  endtask

  function automatic int eff_size(int v);
    if (v == 0) return 1;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return v;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // one setting: fill the source rectangle of some planes, then resize, with some loads mixed in
  task automatic run_phase(int sw, int sh, int dw, int dh, logic mode, int n_mix);
    int ew, eh, ch, kind, dwe, dhe;
    ew  = eff_size(sw);
    eh  = eff_size(sh);
    dwe = (dw == 0) ? 1 : dw;
    dhe = (dh == 0) ? 1 : dh;
    configure(sw, sh, dw, dh, mode);
    for (int c = 0; c < 4; c++)
      chan_ready[c] = (ew * eh > 64) ? 1'b0 : 1'($urandom_range(0, 1));
    chan_ready[$urandom_range(0, 3)] = 1;
    for (int c = 0; c < 4; c++)
      if (chan_ready[c])
        for (int y = 0; y < eh; y++)
          for (int x = 0; x < ew; x++) send_item(FUNC_LOAD, x, y, c, rand_sample());
    for (int n = 0; n < n_mix; n++) begin
      do ch = $urandom_range(0, 3); while (!chan_ready[ch]);
      kind = $urandom_range(0, 19);
      if (kind < 9)
        send_item(FUNC_COMPUTE, $urandom_range(0, dwe > 4096 ? 4095 : dwe - 1),
                  $urandom_range(0, dhe > 4096 ? 4095 : dhe - 1), ch, $urandom());
      else if (kind < 16)
        send_item(FUNC_COMPUTE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  ch, $urandom());
      else if (kind < 19)
        // rewrite a sample inside the rectangle
        send_item(FUNC_LOAD, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                  ch, rand_sample());
      else
        // noise load, column outside the store, so it is ignored
        send_item(FUNC_LOAD, $urandom_range(256, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 3), $urandom());
    end
  endtask

  initial begin
    rst          = 1'b1;
    calm         = 1'b0;
    items_sent   = 0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 2x2 checker image upscaled to 3x3, both modes
    configure(2, 2, 3, 3, ~MODE_NEAREST);
    send_item(FUNC_LOAD, 0, 0, 0, 16'h0000);
    send_item(FUNC_LOAD, 1, 0, 0, 16'hFFFF);
    send_item(FUNC_LOAD, 0, 1, 0, 16'hFFFF);
    send_item(FUNC_LOAD, 1, 1, 0, 16'h0000);
    send_item(FUNC_LOAD, 4095, 4095, 3, 16'hFFFF);  // out of range, ignored
    send_item(FUNC_LOAD, 255, 255, 3, 16'hA5A5);     // last store entry
    send_item(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF);
    send_item(FUNC_COMPUTE, 1, 1, 0, 0);
    send_item(FUNC_COMPUTE, 2, 0, 0, 0);
    send_item(FUNC_COMPUTE, 4095, 4095, 0, 0);      // far outside, clamped
    wait_idle();
    reg_write(3'd5, 32'hFFFF_FFFF);                  // beyond the register list
    reg_write(REG_INTERP_MODE, {31'd0, MODE_NEAREST});
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
    send_item(FUNC_COMPUTE, 1, 1, 0, 0);
    send_item(FUNC_COMPUTE, 2, 2, 0, 0);
    send_item(FUNC_COMPUTE, 0, 4095, 0, 0);

    // extreme settings, then mostly small random ones
    run_phase(256, 1, 4096, 1, ~MODE_NEAREST, 40);
    run_phase(1, 256, 1, 4096, MODE_NEAREST, 40);
    run_phase(0, 0, 0, 0, ~MODE_NEAREST, 30);
    run_phase(511, 1, 8191, 8191, MODE_NEAREST, 30);
    run_phase(1, 511, 1, 2, ~MODE_NEAREST, 30);
    while (items_sent < ITEM_TARGET) begin
      run_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 20),
                $urandom_range(1, 20), 1'($urandom_range(0, 1)), 60);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/irs_pkg.sv
sv/irs_stream_if.sv
sv/irs_ram.sv
sv/irs_map.sv
sv/image_resize_nearest_bilinear.sv
test/image_resize_nearest_bilinear_checker.sv
test/image_resize_nearest_bilinear_tb.sv
